// ===== design/knn_pkg.sv =====
// knn_pkg: shared types, constants and the distance ordering function
// for the k nearest neighbour selector; no dependencies

package knn_pkg;

   localparam int NODE_W    = 10;
   localparam int DIST_W    = 32;
   localparam int RANK_W    = 4;
   localparam int WANTED_W  = 5;
   localparam logic [WANTED_W-1:0] WANTED_RESET = 5'd16;

   localparam int REQ_DATA_W = 56;   // row, candidate, distance, zero filled to bytes
   localparam int RSP_DATA_W = 16;   // neighbour, rank, zero filled to bytes

   // controller to datapath
   typedef struct packed {
      logic take;        // input word accepted this cycle
      logic emit_step;   // load the next list entry into the output register
   } knn_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;    // output register can take a word
      logic emit_final;  // the entry about to be emitted is the last of the list
   } knn_status_type;

   // true when (da, ia) orders strictly after (db, ib)
   function automatic logic orders_after(input logic [DIST_W-1:0] da,
                                         input logic [NODE_W-1:0] ia,
                                         input logic [DIST_W-1:0] db,
                                         input logic [NODE_W-1:0] ib);
      logic res;
      if (da != db) begin
         res = (da > db);
      end else begin
         res = (ia > ib);
      end
      return res;
   endfunction

endpackage

// ===== design/knn_ctrl.sv =====
// knn_ctrl: controller state machine, collects a row then reads out the list
// depends on knn_pkg

module knn_ctrl
   import knn_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   input  logic           req_tlast,
   output logic           req_tready,
   input  knn_status_type status,
   output knn_cmd_type    cmd
);

   localparam logic ST_COLLECT = 1'b0;
   localparam logic ST_EMIT    = 1'b1;

   logic state_ff;
   logic state_in;

   always_comb begin
      state_in       = state_ff;
      req_tready     = 1'b0;
      cmd.take       = 1'b0;
      cmd.emit_step  = 1'b0;
      case (state_ff)
         ST_COLLECT: begin
            req_tready = 1'b1;
            cmd.take   = req_tvalid;
            if (req_tvalid && req_tlast) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit_step = 1'b1;
               if (status.emit_final) begin
                  state_in = ST_COLLECT;
               end
            end
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COLLECT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== design/knn_dp.sv =====
// knn_dp: datapath with the sorted compare-and-shift list, limit register
// and output register; depends on knn_pkg

module knn_dp
   import knn_pkg::*;
#(
   parameter int MAX_NEIGHBOURS = 16,
   parameter int MAX_NODES      = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [WANTED_W-1:0]   csr_wr_data,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  knn_cmd_type           cmd,
   output knn_status_type        status,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   output logic                  rsp_tuser
);

   localparam int CNT_W = $clog2(MAX_NEIGHBOURS + 1);
   localparam int IDX_W = (MAX_NEIGHBOURS > 1) ? $clog2(MAX_NEIGHBOURS) : 1;

   logic [NODE_W-1:0] row_node;
   logic [NODE_W-1:0] cand_node;
   logic [DIST_W-1:0] cand_dist;

   assign row_node  = req_tdata[NODE_W-1:0];
   assign cand_node = req_tdata[2*NODE_W-1:NODE_W];
   assign cand_dist = req_tdata[2*NODE_W+DIST_W-1:2*NODE_W];

   logic [WANTED_W-1:0] wanted_ff;
   logic [CNT_W-1:0]    limit;
   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;
   logic [CNT_W-1:0]    list_len;
   logic [IDX_W-1:0]    idx_ff;
   logic [IDX_W-1:0]    idx_in;

   logic [DIST_W-1:0] kept_dist_ff [MAX_NEIGHBOURS];
   logic [NODE_W-1:0] kept_id_ff   [MAX_NEIGHBOURS];
   logic [DIST_W-1:0] kept_dist_in [MAX_NEIGHBOURS];
   logic [NODE_W-1:0] kept_id_in   [MAX_NEIGHBOURS];

   logic [MAX_NEIGHBOURS-1:0] stays_ahead;   // kept entry sorts at or before the new one
   logic [MAX_NEIGHBOURS-1:0] below_limit;
   logic cand_ok;
   logic ins_ok;
   logic empty;

   logic                  rsp_valid_ff;
   logic [NODE_W-1:0]     rsp_node_ff;
   logic [RANK_W-1:0]     rsp_rank_ff;
   logic                  rsp_last_ff;
   logic                  rsp_empty_ff;

   always_comb begin
      if (32'(wanted_ff) > 32'(MAX_NEIGHBOURS)) begin
         limit = CNT_W'(MAX_NEIGHBOURS);
      end else begin
         limit = CNT_W'(wanted_ff);
      end
      list_len = (count_ff > limit) ? limit : count_ff;
   end

   assign cand_ok = (row_node != '0) && (cand_node != '0) && (cand_node != row_node) &&
                    (32'(cand_node) < 32'(MAX_NODES)) && (limit != '0);

   always_comb begin
      for (int i = 0; i < MAX_NEIGHBOURS; i++) begin
         stays_ahead[i] = (CNT_W'(i) < count_ff) &&
                          !orders_after(kept_dist_ff[i], kept_id_ff[i], cand_dist, cand_node);
         below_limit[i] = (CNT_W'(i) < limit);
      end
   end

   assign ins_ok = cand_ok && (|(~stays_ahead & below_limit));

   // one lane per list slot: keep, take the new word, or take the neighbour below
   for (genvar g = 0; g < MAX_NEIGHBOURS; g++) begin : g_lane
      logic from_new;
      if (g == 0) begin : g_first
         assign from_new = 1'b1;
      end else begin : g_rest
         assign from_new = stays_ahead[g-1];
      end
      always_comb begin
         kept_dist_in[g] = kept_dist_ff[g];
         kept_id_in[g]   = kept_id_ff[g];
         if (cmd.take && ins_ok && !stays_ahead[g]) begin
            if (from_new) begin
               kept_dist_in[g] = cand_dist;
               kept_id_in[g]   = cand_node;
            end else begin
               kept_dist_in[g] = kept_dist_ff[(g > 0) ? g - 1 : 0];
               kept_id_in[g]   = kept_id_ff[(g > 0) ? g - 1 : 0];
            end
         end
      end
   end

   assign empty             = (list_len == '0);
   assign status.emit_final = ((CNT_W'(idx_ff) + CNT_W'(1)) >= list_len);
   assign status.out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      count_in = count_ff;
      idx_in   = idx_ff;
      if (cmd.emit_step) begin
         if (status.emit_final) begin
            count_in = '0;
            idx_in   = '0;
         end else begin
            idx_in = idx_ff + IDX_W'(1);
         end
      end else if (cmd.take && ins_ok) begin
         count_in = (count_ff < limit) ? count_ff + CNT_W'(1) : limit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wanted_ff    <= WANTED_RESET;
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            wanted_ff <= csr_wr_data;
         end
         count_ff <= count_in;
         idx_ff   <= idx_in;
         if (cmd.emit_step) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_NEIGHBOURS; i++) begin
         kept_dist_ff[i] <= kept_dist_in[i];
         kept_id_ff[i]   <= kept_id_in[i];
      end
      if (cmd.emit_step) begin
         rsp_node_ff  <= empty ? '0 : kept_id_ff[idx_ff];
         rsp_rank_ff  <= empty ? '0 : RANK_W'(idx_ff);
         rsp_last_ff  <= status.emit_final;
         rsp_empty_ff <= empty;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - NODE_W - RANK_W){1'b0}}, rsp_rank_ff, rsp_node_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_empty_ff;

endmodule

// ===== design/k_nearest_neighbour_selector.sv =====
// k_nearest_neighbour_selector: top level, joins controller and datapath
// depends on knn_pkg, knn_ctrl, knn_dp
// throughput: one candidate word per cycle within a row; the row's last word is
//    followed by list read-out, one result word per cycle while rsp_tready is high;
//    an empty list still gives one result word, marked list_empty
// first word: the controller enters read-out, then the output register loads it
// reset: synchronous, clears the kept count, controller state and output valid,
//    and sets neighbours_wanted to 16; the kept list storage is not cleared

module k_nearest_neighbour_selector
   import knn_pkg::*;
#(
   parameter int MAX_NEIGHBOURS = 16,   // slots in the sorted list
   parameter int MAX_NODES      = 1024  // candidate ids at or above this are ignored
) (
   input  logic                  clock,
   input  logic                  reset,
   // configuration: neighbours_wanted
   input  logic                  csr_wr_en,
   input  logic [WANTED_W-1:0]   csr_wr_data,
   // candidate words
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // row_node, candidate_node, distance
   input  logic                  req_tlast,   // last_candidate
   // neighbour list words
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // neighbour_node, rank
   output logic                  rsp_tlast,   // last_of_list
   output logic                  rsp_tuser    // list_empty
);

   knn_cmd_type    cmd;
   knn_status_type status;

   // controller: takes candidates until the row's last word, then steps the read-out
   knn_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // datapath: parallel compare-and-shift insertion and the output register
   knn_dp #(
      .MAX_NEIGHBOURS (MAX_NEIGHBOURS),
      .MAX_NODES      (MAX_NODES)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tdata   (req_tdata),
      .cmd         (cmd),
      .status      (status),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser)
   );

endmodule

// ===== test/tb_k_nearest_neighbour_selector.sv =====
// tb_k_nearest_neighbour_selector: self-checking bench for the k nearest neighbour selector
// depends on knn_pkg and k_nearest_neighbour_selector; keeps its own sorted-list predictor
// and checks every list word against it under random valid and ready gaps

`timescale 1ns / 100ps

module tb_k_nearest_neighbour_selector;
   import knn_pkg::*;

   localparam int LIST_SLOTS    = 16;       // list depth of the block as built
   localparam int SETTLE_CYCLES = 8;        // drain time after the last predicted word is seen
   localparam int CYCLE_LIMIT   = 400000;   // hard stop for a hung run
   localparam int MAX_REPORTS   = 40;       // cap on printed mismatches

   // one list word as the block presents it
   typedef struct packed {
      logic [NODE_W-1:0] node;
      logic [RANK_W-1:0] rank;
      logic              last;
      logic              empty;
   } neighbour_word_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   // block inputs, all known from time zero
   logic                  csr_wr_en   = 1'b0;
   logic [WANTED_W-1:0]   csr_wr_data = '0;
   logic                  req_tvalid  = 1'b0;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;   // row_node, candidate_node, distance
   logic                  req_tlast   = 1'b0; // last_candidate
   logic                  rsp_tready  = 1'b0;

   // block outputs
   logic                  req_tready;
   logic                  rsp_tvalid;
   logic [RSP_DATA_W-1:0] rsp_tdata;          // neighbour_node, rank
   logic                  rsp_tlast;          // last_of_list
   logic                  rsp_tuser;          // list_empty

   // predictor copy of the register and the sorted list
   logic [WANTED_W-1:0]   wanted_shadow = WANTED_RESET;
   logic [DIST_W-1:0]     list_dist [LIST_SLOTS];
   logic [NODE_W-1:0]     list_ids  [LIST_SLOTS];
   int                    list_len = 0;

   // list words predicted but not yet seen
   neighbour_word_type    pending_neighbours [$];

   // idling controls shared by the sender, the receiver and the tests
   bit                    send_gaps    = 1'b1;
   bit                    recv_stalls  = 1'b1;
   int                    hold_off_cycles = 0;

   // run statistics
   int                    error_count   = 0;
   int                    words_sent    = 0;
   int                    rows_sent     = 0;
   int                    words_checked = 0;
   int                    settings_used = 1;
   int                    longest_full  = 0;
   int                    cycle_count   = 0;

   k_nearest_neighbour_selector dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser)
   );

   always #2 clock = ~clock;

   // timeout guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d list words outstanding",
                  $realtime, cycle_count, pending_neighbours.size());
         $display("tb_k_nearest_neighbour_selector: errors");
         $finish;
      end
   end

   function automatic int draw_gap(input bit enabled);
      return enabled ? int'($urandom_range(0, 8)) : 0;
   endfunction

   // ------------------------------------------------------------------
   // predictor: sorted (distance, id) insertion and list read-out
   // ------------------------------------------------------------------
   function automatic void update_neighbour_list(input logic [NODE_W-1:0] row,
                                                 input logic [NODE_W-1:0] cand,
                                                 input logic [DIST_W-1:0] cand_dist,
                                                 input logic              last);
      int                 limit;
      int                 count;
      int                 pos;
      int                 grown;
      int                 t;
      int                 n;
      neighbour_word_type w;

      // anything above the list depth behaves as a full list
      limit = (wanted_shadow > LIST_SLOTS) ? LIST_SLOTS : int'(wanted_shadow);

      // depot, self and an empty limit are skipped; every 10-bit id is in range
      if (row != 0 && cand != 0 && cand != row && limit > 0) begin
         count = (list_len > LIST_SLOTS) ? LIST_SLOTS : list_len;
         pos = 0;
         // walk past entries that do not order strictly after the newcomer,
         // so equal distance and equal id land behind the earlier entry
         while (pos < count &&
                !((list_dist[pos] != cand_dist) ? (list_dist[pos] > cand_dist)
                                                : (list_ids[pos] > cand)))
            pos++;
         if (pos < limit) begin
            // a lowered limit cuts the list here
            grown = (count < limit) ? count + 1 : limit;
            for (t = grown - 1; t > pos; t--) begin
               list_dist[t] = list_dist[t-1];
               list_ids[t]  = list_ids[t-1];
            end
            list_dist[pos] = cand_dist;
            list_ids[pos]  = cand;
            list_len       = grown;
         end
      end

      if (last) begin
         n = (list_len > limit) ? limit : list_len;
         list_len = 0;
         rows_sent++;
         if (n == 0) begin
            w = '{node: '0, rank: '0, last: 1'b1, empty: 1'b1};
            pending_neighbours.insert(pending_neighbours.size(), w);
         end else begin
            for (t = 0; t < n; t++) begin
               w.node  = list_ids[t];
               w.rank  = t[RANK_W-1:0];
               w.last  = (t + 1 == n);
               w.empty = 1'b0;
               pending_neighbours.insert(pending_neighbours.size(), w);
            end
         end
      end
   endfunction

   // ------------------------------------------------------------------
   // sender: one candidate word, held until the block takes it
   // ------------------------------------------------------------------
   task automatic send_candidate(input logic [NODE_W-1:0] row,
                                 input logic [NODE_W-1:0] cand,
                                 input logic [DIST_W-1:0] cand_dist,
                                 input logic              last);
      int gap;
      int full_run;
      gap = draw_gap(send_gaps);
      full_run = 0;
      // valid only drops when a gap follows, so it never toggles within one step
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0000, cand_dist, cand, row};
      req_tlast  <= last;
      do begin
         @(posedge clock);
         if (!req_tready) full_run++;
      end while (req_tready !== 1'b1);
      if (full_run > longest_full) longest_full = full_run;
      words_sent++;
      update_neighbour_list(row, cand, cand_dist, last);
   endtask

   // stop offering words and wait until the block has nothing left to say
   task automatic drain_block();
      req_tvalid <= 1'b0;
      while (pending_neighbours.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // register write while the block is quiet
   task automatic write_wanted(input logic [WANTED_W-1:0] value);
      drain_block();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      wanted_shadow = value;
      settings_used++;
   endtask

   // ------------------------------------------------------------------
   // receiver: random ready gaps, plus the long hold-off when asked
   // ------------------------------------------------------------------
   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_cycles > 0) begin
            stall = hold_off_cycles;
            hold_off_cycles = 0;
         end else begin
            stall = draw_gap(recv_stalls);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid === 1'b1 && rsp_tready === 1'b1));
      end
   end

   // ------------------------------------------------------------------
   // checker: every accepted list word against the oldest prediction
   // ------------------------------------------------------------------
   task automatic compare_field(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         error_count++;
         if (error_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d actual %0d",
                     $realtime, what, want, got);
      end
   endtask

   always @(posedge clock) begin : check_words
      neighbour_word_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         if (pending_neighbours.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("%0t: unexpected list word, expected none actual node %0d rank %0d",
                        $realtime, rsp_tdata[NODE_W-1:0], rsp_tdata[NODE_W+RANK_W-1:NODE_W]);
         end else begin
            want = pending_neighbours.pop_front();
            words_checked++;
            compare_field("neighbour_node", 32'(want.node), 32'(rsp_tdata[NODE_W-1:0]));
            compare_field("rank", 32'(want.rank),
                          32'(rsp_tdata[NODE_W+RANK_W-1:NODE_W]));
            compare_field("tdata fill", 32'd0,
                          32'(rsp_tdata[RSP_DATA_W-1:NODE_W+RANK_W]));
            compare_field("last_of_list", 32'(want.last), 32'(rsp_tlast));
            compare_field("list_empty", 32'(want.empty), 32'(rsp_tuser));
         end
      end
   end

   // ------------------------------------------------------------------
   // directed tests
   // ------------------------------------------------------------------

   // field extremes, depot and self skipped, ties broken by id then by arrival
   task automatic test_ordering_extremes();
      send_candidate(10'd1023, 10'd1022, 32'hFFFF_FFFF, 1'b0);
      send_candidate(10'd1023, 10'd0,    32'h0000_0000, 1'b0);   // depot
      send_candidate(10'd1023, 10'd1023, 32'h0000_0000, 1'b0);   // row node itself
      send_candidate(10'd1023, 10'd7,    32'd5,         1'b0);
      send_candidate(10'd1023, 10'd3,    32'd5,         1'b0);   // lower id wins the tie
      send_candidate(10'd1023, 10'd3,    32'd5,         1'b0);   // exact duplicate goes behind
      send_candidate(10'd1023, 10'd1,    32'h0000_0000, 1'b0);
      send_candidate(10'd1023, 10'd512,  32'hAAAA_AAAA, 1'b0);
      send_candidate(10'd1023, 10'd341,  32'h5555_5555, 1'b1);
   endtask

   // rows that end with nothing kept
   task automatic test_empty_rows();
      send_candidate(10'd0, 10'd5, 32'd1, 1'b0);                 // depot row
      send_candidate(10'd0, 10'd9, 32'd2, 1'b1);
      send_candidate(10'd5, 10'd5, 32'd0, 1'b1);                 // only itself offered
   endtask

   // row_node is judged per word, not latched at the start of the row
   task automatic test_row_change();
      send_candidate(10'd10, 10'd20, 32'd40, 1'b0);
      send_candidate(10'd20, 10'd20, 32'd10, 1'b0);              // self for this word
      send_candidate(10'd0,  10'd30, 32'd10, 1'b0);              // depot row for this word
      send_candidate(10'd30, 10'd10, 32'd30, 1'b1);
   endtask

   // zero neighbours wanted answers every row empty
   task automatic test_zero_wanted();
      write_wanted(5'd0);
      send_candidate(10'd4, 10'd1, 32'd3, 1'b0);
      send_candidate(10'd4, 10'd2, 32'd1, 1'b1);
   endtask

   // limit lowered between words of one row cuts the list
   task automatic test_limit_cut();
      int i;
      write_wanted(5'd16);
      for (i = 1; i <= 5; i++)
         send_candidate(10'd100, i[NODE_W-1:0], 32'd100 - i, 1'b0);
      write_wanted(5'd2);
      send_candidate(10'd100, 10'd6, 32'd0, 1'b1);
   endtask

   // ------------------------------------------------------------------
   // random tests
   // ------------------------------------------------------------------

   // one row: mostly ascending ids with random distances, some noise
   task automatic send_random_row();
      int                len;
      int                i;
      int                pick;
      bit                narrow;
      logic [NODE_W-1:0] row;
      logic [NODE_W-1:0] word_row;
      logic [NODE_W-1:0] cand;
      logic [NODE_W-1:0] offered;
      logic [DIST_W-1:0] cand_dist;

      send_gaps   = ($urandom_range(0, 3) != 0);
      recv_stalls = ($urandom_range(0, 3) != 0);
      len    = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 22) : $urandom_range(1, 6);
      row    = ($urandom_range(0, 24) == 0) ? 10'd0 : NODE_W'($urandom_range(1, 1023));
      narrow = ($urandom_range(0, 2) == 0);   // small distances force ties
      cand   = NODE_W'($urandom_range(1, 900));
      for (i = 0; i < len; i++) begin
         pick     = $urandom_range(0, 19);
         word_row = row;
         cand     = cand + NODE_W'($urandom_range(1, 3));
         case (pick)
            0:       offered = 10'd0;
            1:       offered = row;
            2:       offered = NODE_W'($urandom);
            3: begin
               offered  = cand;
               word_row = NODE_W'($urandom);
            end
            default: offered = cand;
         endcase
         cand_dist = narrow ? DIST_W'($urandom_range(0, 7)) : DIST_W'($urandom);
         send_candidate(word_row, offered, cand_dist, i == len - 1);
      end
   endtask

   task automatic send_random_rows(input int word_budget);
      int stop_at;
      stop_at = words_sent + word_budget;
      while (words_sent < stop_at) send_random_row();
   endtask

   // walk through limits, extremes and values above the list depth among them
   task automatic test_random_settings();
      logic [WANTED_W-1:0] settings [6];
      int                  s;
      settings[0] = 5'd1;
      settings[1] = 5'd31;
      settings[2] = 5'd17;
      settings[3] = WANTED_W'($urandom_range(2, 15));
      settings[4] = 5'd16;
      settings[5] = WANTED_W'($urandom_range(0, 31));
      for (s = 0; s < 6; s++) begin
         write_wanted(settings[s]);
         send_random_rows(45);
      end
   endtask

   // receiver holds off for a long stretch while rows keep coming back to back
   task automatic test_backpressure();
      int i;
      write_wanted(5'd16);
      hold_off_cycles = 300;
      for (i = 0; i < 5; i++) begin
         send_gaps = 1'b0;
         send_candidate(NODE_W'(200 + i), NODE_W'(1 + 2 * i), DIST_W'($urandom), 1'b0);
         send_candidate(NODE_W'(200 + i), NODE_W'(2 + 2 * i), DIST_W'($urandom), 1'b0);
         send_candidate(NODE_W'(200 + i), NODE_W'(300 + i),   DIST_W'($urandom), 1'b1);
      end
      send_random_rows(25);
   endtask

   // ------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_ordering_extremes();
      test_empty_rows();
      test_row_change();
      test_zero_wanted();
      test_limit_cut();
      test_random_settings();
      test_backpressure();

      drain_block();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("run covered %0d candidate words in %0d rows, %0d list words checked",
               words_sent, rows_sent, words_checked);
      $display("limit written %0d times, longest input stall %0d cycles",
               settings_used - 1, longest_full);
      if (error_count == 0 && pending_neighbours.size() == 0) begin
         $display("tb_k_nearest_neighbour_selector: clean");
      end else begin
         $display("tb_k_nearest_neighbour_selector: errors");
      end
      $finish;
   end

endmodule
